// File: rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes, types and the circular address helper of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // storage geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    // field widths
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // request codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

    // status of one finished request, handed to the output stage
    typedef struct packed {
        logic               ok;
        logic               is_empty;
        logic               is_full;
        logic [CNT_W-1:0]   count;
    } status_t;

    // circular slot of base + off, with base and off both below DEPTH
    function automatic logic [ADDR_W-1:0] wrap_add(
        input logic [ADDR_W-1:0] base,
        input logic [CNT_W-1:0]  off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/bdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: rtl/bdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head pointer, count and capacity registers, request decode and sequencer
// that drives the entry memory.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bdq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bdq_pkg::CMD_W-1:0]    s_cmd,
    input  logic [bdq_pkg::WORD_W-1:0]   s_value,
    output logic                         ram_wr_en,
    output logic [bdq_pkg::ADDR_W-1:0]   ram_wr_addr,
    output logic [bdq_pkg::WORD_W-1:0]   ram_wr_data,
    output logic [bdq_pkg::ADDR_W-1:0]   ram_rd_front,
    output logic [bdq_pkg::ADDR_W-1:0]   ram_rd_rear,
    input  logic                         out_free,
    output logic                         out_load,
    output bdq_pkg::status_t             out_status
);
    import bdq_pkg::*;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ok_reg, ok_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CMP_W-1:0]   eff_cap;
    logic               is_full;
    logic               is_empty;
    logic               accept;
    logic [ADDR_W-1:0]  head_dec;
    logic [ADDR_W-1:0]  head_inc;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // effective capacity and flags from the current count
    assign eff_cap  = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign is_full  = CMP_W'(count_reg) >= eff_cap;
    assign is_empty = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // read addresses follow the updated pointer and count
    assign ram_rd_front = head_reg;
    assign ram_rd_rear  = wrap_add(head_reg, is_empty ? '0 : count_reg - 1'b1);

    // request decode and sequencer
    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wrap_add(head_reg, count_reg[CNT_W-1:0]);
        ram_wr_data = s_value;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ok_next    = 1'b0;
                    state_next = ST_READ;
                    case (s_cmd)
                        CMD_PUSH_FRONT: begin
                            if (!is_full) begin
                                head_next   = head_dec;
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = head_dec;
                                count_next  = count_reg + 1'b1;
                                ok_next     = 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (!is_full) begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (!is_empty) begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (!is_empty) begin
                                count_next = count_reg - 1'b1;
                                ok_next    = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            ok_next = 1'b1;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // read data is valid; hand over once the output slot is free
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_status.ok       = ok_reg;
    assign out_status.is_empty = is_empty;
    assign out_status.is_full  = is_full;
    assign out_status.count    = count_reg;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

`ifndef NO_ASSERTIONS
    // count never exceeds the storage depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above depth");

    // count moves by at most one per request
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (count_reg == $past(count_reg)) ||
                   (count_reg == $past(count_reg) + 1'b1) ||
                   (count_reg == $past(count_reg) - 1'b1))
        else $error("count jumped");

    // pointer and count only change on an accepted item
    a_hold_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(head_reg) && $stable(count_reg))
        else $error("state changed without an item");

    // memory is written only while an item is taken
    a_write_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> accept)
        else $error("stray memory write");
`endif

endmodule

// File: rtl/bdq_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_out
// Output register: merges read data with request status and holds the
// result item until the consumer takes it.
// ----------------------------------------------------------------------------
module bdq_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  bdq_pkg::status_t             status,
    input  logic [bdq_pkg::WORD_W-1:0]   front_data,
    input  logic [bdq_pkg::WORD_W-1:0]   rear_data,
    output logic                         free,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic signed [bdq_pkg::WORD_W-1:0] m_front_value,
    output logic signed [bdq_pkg::WORD_W-1:0] m_rear_value,
    output logic                         m_is_empty,
    output logic                         m_is_full,
    output logic [bdq_pkg::COUNT_W-1:0]  m_count
);
    import bdq_pkg::*;

    logic               valid_reg;
    logic               ok_reg;
    logic [WORD_W-1:0]  front_reg;
    logic [WORD_W-1:0]  rear_reg;
    logic               empty_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] count_reg;

    assign free = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload, empty deque reads as all ones
    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg    <= status.ok;
            front_reg <= status.is_empty ? EMPTY_WORD : front_data;
            rear_reg  <= status.is_empty ? EMPTY_WORD : rear_data;
            empty_reg <= status.is_empty;
            full_reg  <= status.is_full;
            count_reg <= COUNT_W'(status.count);
        end
    end

    assign m_valid       = valid_reg;
    assign m_ok          = ok_reg;
    assign m_front_value = front_reg;
    assign m_rear_value  = rear_reg;
    assign m_is_empty    = empty_reg;
    assign m_is_full     = full_reg;
    assign m_count       = count_reg;

endmodule

// File: rtl/bounded_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed words in a circular memory addressed from a head
// pointer; every request reports front, rear, flags and count.
// ----------------------------------------------------------------------------
//  channel  | ports                         | handshake
//  ---------+-------------------------------+------------------
//  request  | s_cmd, s_value                | s_valid / s_ready
//  result   | m_ok, m_front_value, m_rear_value,
//           | m_is_empty, m_is_full, m_count| m_valid / m_ready
//  config   | cfg_wr_data (capacity)        | cfg_wr_en
//
// Each item goes through accept and memory write, read issue (the memory read is
// registered) and capture into the output register before the next is accepted.
// Reset clears pointer and count and sets capacity to 16; entries are not cleared.
// A result waiting in the output register does not stop the next item from
// being accepted; it stalls only in its final state until the slot frees.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bdq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bdq_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [bdq_pkg::WORD_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic signed [bdq_pkg::WORD_W-1:0] m_front_value,
    output logic signed [bdq_pkg::WORD_W-1:0] m_rear_value,
    output logic                         m_is_empty,
    output logic                         m_is_full,
    output logic [bdq_pkg::COUNT_W-1:0]  m_count
);
    import bdq_pkg::*;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_front;
    logic [ADDR_W-1:0] ram_rd_rear;
    logic [WORD_W-1:0] front_data;
    logic [WORD_W-1:0] rear_data;
    logic              out_free;
    logic              out_load;
    status_t           out_status;

    // pointer, count and sequencing
    bdq_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_value      (s_value),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_front (ram_rd_front),
        .ram_rd_rear  (ram_rd_rear),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_status   (out_status)
    );

    // entry store
    bdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_front),
        .rd_addr_b (ram_rd_rear),
        .rd_data_a (front_data),
        .rd_data_b (rear_data)
    );

    // result register
    bdq_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (out_load),
        .status        (out_status),
        .front_data    (front_data),
        .rear_data     (rear_data),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_front_value (m_front_value),
        .m_rear_value  (m_rear_value),
        .m_is_empty    (m_is_empty),
        .m_is_full     (m_is_full),
        .m_count       (m_count)
    );

endmodule
